// ----- hdl/kmcd_pkg.sv -----
package kmcd_pkg;

  // Matrix geometry and field widths
  localparam int MAX_COLUMNS = 16;
  localparam int COL_W       = 4;
  localparam int ROW_W       = 8;
  localparam int ROWIDX_W    = 3;
  localparam int ROWCNT_W    = 4;
  localparam int KIND_W      = 2;
  localparam int CODE_W      = ROWIDX_W + COL_W;
  localparam int PC_W        = 2;

  localparam logic [ROWCNT_W-1:0] ROWS_RESET = 4'd8;
  localparam logic [ROWCNT_W-1:0] ROWS_MAX   = 4'd8;
  localparam logic [ROW_W-1:0]    ALL_HIGH   = 8'hFF;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_EVENT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REARM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POLL  = 2'd2;

  // Program addresses
  localparam logic [PC_W-1:0] PC_WAIT   = 2'd0;
  localparam logic [PC_W-1:0] PC_ROW    = 2'd1;
  localparam logic [PC_W-1:0] PC_COMMIT = 2'd2;
  localparam logic [PC_W-1:0] PC_END    = 2'd3;

  // Jump conditions: jump to target when true, else fall through
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_NO_ACCEPT,
    COND_ROW_MORE,
    COND_NOT_LAST
  } cond_e;

  typedef struct packed {
    logic            take_in;
    logic            scan_row;
    logic            commit;
    logic            emit_end;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic accepted;
    logic row_more;
    logic last_col;
    logic stall;
  } dp_status_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{take_in: 1'b0, scan_row: 1'b0, commit: 1'b0, emit_end: 1'b0,
          cond: COND_ALWAYS, target: PC_WAIT};
    unique case (pc)
      PC_WAIT: begin
        w.take_in = 1'b1;
        w.cond    = COND_NO_ACCEPT;
        w.target  = PC_WAIT;
      end
      PC_ROW: begin
        w.scan_row = 1'b1;
        w.cond     = COND_ROW_MORE;
        w.target   = PC_ROW;
      end
      PC_COMMIT: begin
        w.commit = 1'b1;
        w.cond   = COND_NOT_LAST;
        w.target = PC_WAIT;
      end
      PC_END: begin
        w.emit_end = 1'b1;
        w.cond     = COND_ALWAYS;
        w.target   = PC_WAIT;
      end
      default: ;
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/kmcd_in_if.sv -----
interface kmcd_in_if
  import kmcd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column_index;
  logic [ROW_W-1:0] row_sample;
  logic             last_column;

  modport source (output valid, column_index, row_sample, last_column, input ready);
  modport sink   (input valid, column_index, row_sample, last_column, output ready);
endinterface

// ----- hdl/kmcd_out_if.sv -----
interface kmcd_out_if
  import kmcd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CODE_W-1:0] scan_code;
  logic              pressed;
  logic              last;

  modport source (output valid, kind, scan_code, pressed, last, input ready);
  modport sink   (input valid, kind, scan_code, pressed, last, output ready);
endinterface

// ----- hdl/kmcd_useq.sv -----
module kmcd_useq
  import kmcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output ucode_t     uword_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          uw;
  logic            take_jump;

  assign uw      = ucode_rom(pc_q);
  assign uword_o = uw;

  // Branch condition select
  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:    take_jump = 1'b1;
      COND_NO_ACCEPT: take_jump = !status_i.accepted;
      COND_ROW_MORE:  take_jump = status_i.row_more;
      COND_NOT_LAST:  take_jump = !status_i.last_col;
      default:        take_jump = 1'b1;
    endcase
  end

  // Next step: hold on output backpressure
  always_comb begin
    priority if (status_i.stall) begin
      pc_d = pc_q;
    end else if (take_jump) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- hdl/kmcd_dp.sv -----
module kmcd_dp
  import kmcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ROWCNT_W-1:0] cfg_data_i,
  input  ucode_t              uword_i,
  output dp_status_t          status_o,
  kmcd_in_if.sink             in_ch,
  kmcd_out_if.source          out_ch
);

  logic [ROWCNT_W-1:0] row_count_q;
  logic [ROW_W-1:0]    col_state_q [MAX_COLUMNS];
  logic [ROW_W-1:0]    acc_q;

  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    now_q;
  logic [ROW_W-1:0]    changed_q;
  logic                any_q;
  logic                last_col_q;
  logic [ROWIDX_W-1:0] row_q;
  logic [ROWCNT_W-1:0] rows_q;

  logic                out_valid_q;
  logic [KIND_W-1:0]   out_kind_q;
  logic [CODE_W-1:0]   out_code_q;
  logic                out_pressed_q;
  logic                out_last_q;

  logic                accepted;
  logic [ROWCNT_W-1:0] rows_clamped;
  logic [ROW_W-1:0]    rows_mask;
  logic [ROW_W-1:0]    now_in;
  logic [ROW_W-1:0]    changed_in;
  logic                rest_any;
  logic                emit_ev;
  logic                emit_any;
  logic                slot_free;
  logic                stall;

  assign in_ch.ready = uword_i.take_in;
  assign accepted    = in_ch.valid && in_ch.ready;

  // Row count clamp and mask of checked rows
  assign rows_clamped = (row_count_q > ROWS_MAX) ? ROWS_MAX : row_count_q;
  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      rows_mask[i] = (ROWCNT_W'(i) < rows_clamped);
    end
  end

  assign now_in     = ~in_ch.row_sample;
  assign changed_in = (col_state_q[in_ch.column_index] ^ now_in) & rows_mask;

  // Changes remaining above the current row, with the last-column flag, decide the last flag
  always_comb begin
    rest_any = 1'b0;
    for (int i = 0; i < ROW_W; i++) begin
      if (ROWIDX_W'(i) > row_q && changed_q[i]) begin
        rest_any = 1'b1;
      end
    end
  end

  assign emit_ev   = uword_i.scan_row && changed_q[row_q];
  assign emit_any  = emit_ev || uword_i.emit_end;
  assign slot_free = !out_valid_q || out_ch.ready;
  assign stall     = emit_any && !slot_free;

  assign status_o.accepted = accepted;
  assign status_o.row_more = ({1'b0, row_q} + 1'b1) < rows_q;
  assign status_o.last_col = last_col_q;
  assign status_o.stall    = stall;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROWS_RESET;
    end else if (cfg_we_i) begin
      row_count_q <= cfg_data_i;
    end
  end

  // Column state, written back only when the column produced events
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        col_state_q[i] <= '0;
      end
    end else if (uword_i.commit && any_q) begin
      col_state_q[col_q] <= now_q;
    end
  end

  // Released-key accumulator over one scan pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= ALL_HIGH;
    end else if (accepted) begin
      acc_q <= acc_q & in_ch.row_sample;
    end else if (uword_i.emit_end && !stall) begin
      acc_q <= ALL_HIGH;
    end
  end

  // Item working registers
  always_ff @(posedge clk_i) begin
    if (accepted) begin
      col_q      <= in_ch.column_index;
      now_q      <= now_in;
      changed_q  <= changed_in;
      any_q      <= |changed_in;
      last_col_q <= in_ch.last_column;
      rows_q     <= rows_clamped;
    end
  end

  // Row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (accepted) begin
      row_q <= '0;
    end else if (uword_i.scan_row && !stall) begin
      row_q <= row_q + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_any && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_any && slot_free) begin
      if (emit_ev) begin
        out_kind_q    <= KIND_EVENT;
        out_code_q    <= {row_q, col_q};
        out_pressed_q <= now_q[row_q];
        out_last_q    <= !rest_any && !last_col_q;
      end else begin
        out_kind_q    <= (acc_q != ALL_HIGH) ? KIND_POLL : KIND_REARM;
        out_code_q    <= '0;
        out_pressed_q <= 1'b0;
        out_last_q    <= 1'b1;
      end
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.kind      = out_kind_q;
  assign out_ch.scan_code = out_code_q;
  assign out_ch.pressed   = out_pressed_q;
  assign out_ch.last      = out_last_q;

endmodule

// ----- hdl/keypad_matrix_change_detector.sv -----
// Key matrix change detector. Each input item is one sampled column (index,
// raw active-low row byte, last-column flag). Every checked row whose state
// differs from the stored column state yields one change event, rows in
// ascending order; the column state is stored only when an event occurred.
// After the last column of a pass one end result follows: poll again while
// any key was seen held, else re-arm the press interrupt. A small microcoded
// sequencer runs each item in steps: take it, step through each checked row
// (row_count clamped to 8, and at least one row step even when row_count is
// zero), write back, and after a last column give the end result; a step
// that emits waits while the output is held off. One item is in work at a
// time. The user must write row_count through cfg_we_i/cfg_data_i only
// while the block is idle; the block itself does not enforce this.
module keypad_matrix_change_detector
  import kmcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ROWCNT_W-1:0] cfg_data_i,
  kmcd_in_if.sink             in_ch,
  kmcd_out_if.source          out_ch
);

  ucode_t     uword;
  dp_status_t status;

  // Control sequencer
  kmcd_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .uword_o  (uword)
  );

  // Datapath
  kmcd_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .uword_i    (uword),
    .status_o   (status),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

endmodule
